@@ src/load_cell_scan_hit_detector_assert.svh @@
// Assertion macros used by the load-cell scanner RTL.
`ifndef LOAD_CELL_SCAN_HIT_DETECTOR_ASSERT_SVH
`define LOAD_CELL_SCAN_HIT_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define LCSHD_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lcshd same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define LCSHD_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lcshd next-cycle check failed");

`endif

@@ src/lcshd_pkg.sv @@
// Types, constants and helper functions of the load-cell scanner.
`timescale 1ns / 1ps

package lcshd_pkg;

    localparam int ChanCount         = 4;
    localparam int ChanW             = 2;
    localparam int ReadingW          = 24;
    localparam int ThreshW           = 24;
    localparam int SampleBitsDefault = 24;
    localparam int CfgRegCount       = 5;
    localparam int CfgIndexW         = $clog2(CfgRegCount);
    localparam int AddrW             = CfgIndexW + 2;
    localparam int DataW             = 32;

    localparam logic [ChanCount-1:0] EnableMaskReset = ChanCount'(14);

    typedef enum logic [CfgIndexW-1:0] {
        REG_ENABLE_MASK = CfgIndexW'(0),
        REG_THRESHOLD_0 = CfgIndexW'(1),
        REG_THRESHOLD_1 = CfgIndexW'(2),
        REG_THRESHOLD_2 = CfgIndexW'(3),
        REG_THRESHOLD_3 = CfgIndexW'(4)
    } cfg_reg_t;

    typedef enum logic [4:0] {
        PH_WAIT  = 5'b00001,
        PH_HIGH  = 5'b00010,
        PH_LOW   = 5'b00100,
        PH_XHIGH = 5'b01000,
        PH_XLOW  = 5'b10000
    } phase_t;

    // any: some channel is enabled; above: one is enabled at or above start.
    typedef struct packed {
        logic             any;
        logic             above;
        logic [ChanW-1:0] chan;
    } pick_t;

    typedef struct packed {
        logic [ChanCount-1:0] sck_lines;
        logic                 reading_valid;
        logic [ChanW-1:0]     reading_channel;
        logic [ReadingW-1:0]  reading_value;
        logic                 sweep_done;
        logic                 hit;
    } result_t;

    // First enabled channel at or above start, else the lowest enabled one.
    function automatic pick_t pick_channel(input logic [ChanCount-1:0] mask,
                                           input logic [ChanW:0]       start);
        pick_t p;
        p = '0;
        for (int n = ChanCount - 1; n >= 0; n--)
        begin
            if (mask[n])
            begin
                p.any  = 1'b1;
                p.chan = ChanW'(n);
            end
        end
        for (int n = ChanCount - 1; n >= 0; n--)
        begin
            if (mask[n] && ((ChanW + 1)'(n) >= start))
            begin
                p.above = 1'b1;
                p.chan  = ChanW'(n);
            end
        end
        return p;
    endfunction

endpackage

@@ src/load_cell_scan_hit_detector.sv @@
// Four-channel two-wire load-cell scanner with per-channel hit thresholds.
`timescale 1ns / 1ps

// Each item transfer is one tick of the serial interface and yields exactly one
// result transfer, which sits in the result register in the cycle after its item
// was taken. An item is accepted in every cycle in which the result register is
// empty or its content is being taken, so the block runs at one item per clock
// for as long as the consumer keeps result_ready high. The scan sequencer, the
// shift register and the threshold compare all settle between the input
// handshake and that result register. Configuration sits on a small APB port;
// thresholds are compared with the reading after its top bit is inverted.
module load_cell_scan_hit_detector #(
    parameter int SAMPLE_BITS = lcshd_pkg::SampleBitsDefault
) (
    input  logic                                     clk,
    input  logic                                     rst_n,

    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [lcshd_pkg::AddrW-1:0]              paddr,
    input  logic [lcshd_pkg::DataW-1:0]              pwdata,
    output logic [lcshd_pkg::DataW-1:0]              prdata,
    output logic                                     pready,

    input  logic                                     item_valid,
    output logic                                     item_ready,
    input  logic [lcshd_pkg::ChanCount-1:0]          dout_lines,

    output logic                                     result_valid,
    input  logic                                     result_ready,
    output logic [lcshd_pkg::ChanCount-1:0]          sck_lines,
    output logic                                     reading_valid,
    output logic [lcshd_pkg::ChanW-1:0]              reading_channel,
    output logic [lcshd_pkg::ReadingW-1:0]           reading_value,
    output logic                                     sweep_done,
    output logic                                     hit
);

    localparam int BitCountW = $clog2(SAMPLE_BITS + 1);
    localparam int CmpW      = (SAMPLE_BITS > lcshd_pkg::ReadingW) ? SAMPLE_BITS
                                                                   : lcshd_pkg::ReadingW;
    localparam logic [SAMPLE_BITS-1:0] SampleTop = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Configuration registers
    logic [lcshd_pkg::ChanCount-1:0] enable_mask_reg;
    logic [lcshd_pkg::ThreshW-1:0]   threshold_reg [lcshd_pkg::ChanCount];

    // Scan state
    lcshd_pkg::phase_t               phase_reg, phase_next;
    logic [lcshd_pkg::ChanW-1:0]     chan_reg, chan_next;
    logic [BitCountW-1:0]            bit_count_reg, bit_count_next;
    logic [SAMPLE_BITS-1:0]          shift_reg, shift_next;
    logic                            hit_acc_reg, hit_acc_next;

    lcshd_pkg::result_t              result_reg, result_next;
    logic                            result_valid_reg;

    logic                            wr_en;
    lcshd_pkg::cfg_reg_t             wr_index;
    logic                            accept;
    lcshd_pkg::pick_t                cur_pick, nxt_pick;
    logic [lcshd_pkg::ChanCount-1:0] chan_onehot;
    logic [SAMPLE_BITS-1:0]          reading;
    logic [CmpW-1:0]                 reading_ext;
    logic [CmpW-1:0]                 threshold_ext;
    logic                            below;
    logic                            acc;
    logic                            last_bit;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign wr_index = lcshd_pkg::cfg_reg_t'(paddr[lcshd_pkg::AddrW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_mask_reg <= lcshd_pkg::EnableMaskReset;
            for (int i = 0; i < lcshd_pkg::ChanCount; i++)
            begin
                threshold_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (wr_index)
                lcshd_pkg::REG_ENABLE_MASK:
                    enable_mask_reg <= pwdata[lcshd_pkg::ChanCount-1:0];
                lcshd_pkg::REG_THRESHOLD_0:
                    threshold_reg[0] <= pwdata[lcshd_pkg::ThreshW-1:0];
                lcshd_pkg::REG_THRESHOLD_1:
                    threshold_reg[1] <= pwdata[lcshd_pkg::ThreshW-1:0];
                lcshd_pkg::REG_THRESHOLD_2:
                    threshold_reg[2] <= pwdata[lcshd_pkg::ThreshW-1:0];
                lcshd_pkg::REG_THRESHOLD_3:
                    threshold_reg[3] <= pwdata[lcshd_pkg::ThreshW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (wr_index)
            lcshd_pkg::REG_ENABLE_MASK: prdata = lcshd_pkg::DataW'(enable_mask_reg);
            lcshd_pkg::REG_THRESHOLD_0: prdata = lcshd_pkg::DataW'(threshold_reg[0]);
            lcshd_pkg::REG_THRESHOLD_1: prdata = lcshd_pkg::DataW'(threshold_reg[1]);
            lcshd_pkg::REG_THRESHOLD_2: prdata = lcshd_pkg::DataW'(threshold_reg[2]);
            lcshd_pkg::REG_THRESHOLD_3: prdata = lcshd_pkg::DataW'(threshold_reg[3]);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Scan sequencer
    // ---------------------------------------------------------------------
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    assign cur_pick = lcshd_pkg::pick_channel(enable_mask_reg, {1'b0, chan_reg});
    assign nxt_pick = lcshd_pkg::pick_channel(enable_mask_reg,
                                              {1'b0, chan_reg} + (lcshd_pkg::ChanW + 1)'(1));

    assign chan_onehot   = lcshd_pkg::ChanCount'(1) << chan_reg;
    assign reading       = shift_reg ^ SampleTop;
    assign reading_ext   = CmpW'(reading);
    assign threshold_ext = CmpW'(threshold_reg[chan_reg]);
    assign below         = reading_ext < threshold_ext;
    assign acc           = hit_acc_reg || below;
    assign last_bit      = bit_count_reg == BitCountW'(SAMPLE_BITS - 1);

    always_comb
    begin
        phase_next     = phase_reg;
        chan_next      = chan_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        hit_acc_next   = hit_acc_reg;
        result_next    = '0;
        case (phase_reg)
            lcshd_pkg::PH_HIGH:
            begin
                result_next.sck_lines = chan_onehot;
                phase_next            = lcshd_pkg::PH_LOW;
            end
            lcshd_pkg::PH_LOW:
            begin
                shift_next     = {shift_reg[SAMPLE_BITS-2:0], dout_lines[chan_reg]};
                bit_count_next = bit_count_reg + BitCountW'(1);
                phase_next     = last_bit ? lcshd_pkg::PH_XHIGH : lcshd_pkg::PH_HIGH;
            end
            lcshd_pkg::PH_XHIGH:
            begin
                result_next.sck_lines = chan_onehot;
                phase_next            = lcshd_pkg::PH_XLOW;
            end
            lcshd_pkg::PH_XLOW:
            begin
                result_next.reading_valid   = 1'b1;
                result_next.reading_channel = chan_reg;
                result_next.reading_value   = reading_ext[lcshd_pkg::ReadingW-1:0];
                // The sweep ends when no enabled channel lies above this one.
                if (nxt_pick.above)
                begin
                    hit_acc_next = acc;
                end
                else
                begin
                    result_next.sweep_done = 1'b1;
                    result_next.hit        = acc;
                    hit_acc_next           = 1'b0;
                end
                if (nxt_pick.any)
                begin
                    chan_next = nxt_pick.chan;
                end
                phase_next = lcshd_pkg::PH_WAIT;
            end
            default:
            begin
                // Waiting for the selected converter to pull its data line low.
                phase_next = lcshd_pkg::PH_WAIT;
                if (cur_pick.any)
                begin
                    chan_next = cur_pick.chan;
                    if (!dout_lines[cur_pick.chan])
                    begin
                        bit_count_next = '0;
                        shift_next     = '0;
                        phase_next     = lcshd_pkg::PH_HIGH;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lcshd_pkg::PH_WAIT;
            chan_reg      <= '0;
            bit_count_reg <= '0;
            hit_acc_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            chan_reg      <= chan_next;
            bit_count_reg <= bit_count_next;
            hit_acc_reg   <= hit_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            shift_reg  <= shift_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            result_valid_reg <= item_valid;
        end
    end

    assign result_valid    = result_valid_reg;
    assign sck_lines       = result_reg.sck_lines;
    assign reading_valid   = result_reg.reading_valid;
    assign reading_channel = result_reg.reading_channel;
    assign reading_value   = result_reg.reading_value;
    assign sweep_done      = result_reg.sweep_done;
    assign hit             = result_reg.hit;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
`include "load_cell_scan_hit_detector_assert.svh"

    `LCSHD_ASSERT_IMP(a_reading_drives_no_clock, result_valid && reading_valid, sck_lines == '0)
    `LCSHD_ASSERT_IMP(a_hit_only_at_sweep_end, result_valid && hit, sweep_done && reading_valid)
    `LCSHD_ASSERT_IMP(a_quiet_tick_fields_clear, result_valid && !reading_valid, reading_value == '0 && reading_channel == '0 && !sweep_done)
    `LCSHD_ASSERT_NEXT(a_item_gives_result, item_valid && item_ready, result_valid)

endmodule

@@ verif/load_cell_scan_hit_detector_tb.sv @@
// Self-checking testbench for the load-cell scanner with per-channel hit thresholds.
`timescale 1ns / 1ps

module load_cell_scan_hit_detector_tb;

    localparam int CycleLimit = 200000;
    localparam int HoldAfter  = 600;
    localparam int HoldCycles = 300;

    // Opening ticks under the reset settings: channel 0 is disabled, so the scan
    // moves to channel 1, waits on a high line, then starts a read.
    localparam logic [lcshd_pkg::ChanCount-1:0] OpeningTicks [16] = '{
        4'hF, 4'hF, 4'hD, 4'h0, 4'hF, 4'h0, 4'hF, 4'h1,
        4'h2, 4'h4, 4'h8, 4'hE, 4'h7, 4'hB, 4'h0, 4'hF
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [lcshd_pkg::AddrW-1:0]     paddr = '0;
    logic [lcshd_pkg::DataW-1:0]     pwdata = '0;
    logic [lcshd_pkg::DataW-1:0]     prdata;
    logic                            pready;

    logic                            item_valid = 1'b0;
    logic                            item_ready;
    logic [lcshd_pkg::ChanCount-1:0] dout_lines = '0;

    logic                            result_valid;
    logic                            result_ready = 1'b0;
    logic [lcshd_pkg::ChanCount-1:0] sck_lines;
    logic                            reading_valid;
    logic [lcshd_pkg::ChanW-1:0]     reading_channel;
    logic [lcshd_pkg::ReadingW-1:0]  reading_value;
    logic                            sweep_done;
    logic                            hit;

    // Copy of the scan state and of the register settings.
    lcshd_pkg::phase_t               scan_phase = lcshd_pkg::PH_WAIT;
    logic [lcshd_pkg::ChanW-1:0]     scan_chan = '0;
    logic [4:0]                      scan_bits = '0;
    logic [lcshd_pkg::ReadingW-1:0]  scan_word = '0;
    logic                            scan_hit_acc = 1'b0;
    logic [lcshd_pkg::ChanCount-1:0] cfg_mask = lcshd_pkg::EnableMaskReset;
    logic [lcshd_pkg::ThreshW-1:0]   cfg_thresh [lcshd_pkg::ChanCount] = '{default: '0};

    logic [lcshd_pkg::ChanCount-1:0] pending_dout [$];
    lcshd_pkg::result_t              expected_results [$];

    bit          idling_on = 1'b1;
    int unsigned mismatches = 0;
    int unsigned results_taken = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned cycle_count = 0;

    load_cell_scan_hit_detector uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .dout_lines      (dout_lines),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .sck_lines       (sck_lines),
        .reading_valid   (reading_valid),
        .reading_channel (reading_channel),
        .reading_value   (reading_value),
        .sweep_done      (sweep_done),
        .hit             (hit)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Lowest enabled channel at or above start, else the lowest enabled one.
    function automatic logic first_enabled(input int start,
                                           output logic [lcshd_pkg::ChanW-1:0] sel);
        logic found;
        found = 1'b0;
        sel = '0;
        for (int n = lcshd_pkg::ChanCount - 1; n >= 0; n--)
        begin
            if (cfg_mask[n])
            begin
                found = 1'b1;
                sel = lcshd_pkg::ChanW'(n);
            end
        end
        for (int n = lcshd_pkg::ChanCount - 1; n >= start; n--)
        begin
            if (cfg_mask[n])
                sel = lcshd_pkg::ChanW'(n);
        end
        return found;
    endfunction

    // Advances the scan by one tick and returns the outputs of that tick.
    function automatic lcshd_pkg::result_t scan_tick(
        input logic [lcshd_pkg::ChanCount-1:0] dout);
        lcshd_pkg::result_t             r;
        logic [lcshd_pkg::ReadingW-1:0] level;
        logic                           acc;
        logic                           later;
        logic [lcshd_pkg::ChanW-1:0]    sel;
        r = '0;
        case (scan_phase)
            lcshd_pkg::PH_HIGH:
            begin
                r.sck_lines = lcshd_pkg::ChanCount'(1) << scan_chan;
                scan_phase = lcshd_pkg::PH_LOW;
            end
            lcshd_pkg::PH_LOW:
            begin
                scan_word = {scan_word[lcshd_pkg::ReadingW-2:0], dout[scan_chan]};
                scan_bits = scan_bits + 1'b1;
                scan_phase = (scan_bits >= lcshd_pkg::SampleBitsDefault)
                             ? lcshd_pkg::PH_XHIGH : lcshd_pkg::PH_HIGH;
            end
            lcshd_pkg::PH_XHIGH:
            begin
                r.sck_lines = lcshd_pkg::ChanCount'(1) << scan_chan;
                scan_phase = lcshd_pkg::PH_XLOW;
            end
            lcshd_pkg::PH_XLOW:
            begin
                level = scan_word ^ (lcshd_pkg::ReadingW'(1) << (lcshd_pkg::ReadingW - 1));
                acc = scan_hit_acc | (level < cfg_thresh[scan_chan]);
                later = 1'b0;
                for (int n = 0; n < lcshd_pkg::ChanCount; n++)
                begin
                    if (n > int'(scan_chan) && cfg_mask[n])
                        later = 1'b1;
                end
                r.reading_valid = 1'b1;
                r.reading_channel = scan_chan;
                r.reading_value = level;
                // The sweep ends when no enabled channel lies above this one.
                if (later)
                    scan_hit_acc = acc;
                else
                begin
                    r.sweep_done = 1'b1;
                    r.hit = acc;
                    scan_hit_acc = 1'b0;
                end
                if (first_enabled(int'(scan_chan) + 1, sel))
                    scan_chan = sel;
                scan_phase = lcshd_pkg::PH_WAIT;
            end
            default:
            begin
                scan_phase = lcshd_pkg::PH_WAIT;
                if (first_enabled(int'(scan_chan), sel))
                begin
                    scan_chan = sel;
                    if (!dout[sel])
                    begin
                        scan_bits = '0;
                        scan_word = '0;
                        scan_phase = lcshd_pkg::PH_HIGH;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [lcshd_pkg::ThreshW-1:0] draw_threshold();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return lcshd_pkg::ThreshW'(24'h800000);
            default: return lcshd_pkg::ThreshW'($urandom);
        endcase
    endfunction

    // Bursts of ticks: mostly random levels, some stretches with every converter
    // busy, and some constant levels that give the extreme readings.
    task automatic queue_ticks(input int count);
        int                              kind;
        int                              len;
        logic [lcshd_pkg::ChanCount-1:0] level;
        int                              n;
        n = 0;
        while (n < count)
        begin
            kind = $urandom_range(99);
            len = $urandom_range(40, 1);
            level = lcshd_pkg::ChanCount'($urandom_range(15));
            for (int i = 0; i < len && n < count; i++)
            begin
                if (kind < 70)
                    pending_dout.push_back(lcshd_pkg::ChanCount'($urandom_range(15)));
                else if (kind < 85)
                    pending_dout.push_back('1);
                else
                    pending_dout.push_back(level);
                n++;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_dout.size() != 0 || item_valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input lcshd_pkg::cfg_reg_t idx,
                             input logic [lcshd_pkg::DataW-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == lcshd_pkg::REG_ENABLE_MASK)
            cfg_mask = val[lcshd_pkg::ChanCount-1:0];
        else
            cfg_thresh[int'(idx) - int'(lcshd_pkg::REG_THRESHOLD_0)] =
                val[lcshd_pkg::ThreshW-1:0];
    endtask

    // Sender: one dout item per transfer, with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && item_ready)
                expected_results.push_back(scan_tick(dout_lines));
            if (!item_valid || item_ready)
            begin
                if (pending_dout.size() != 0 && !(idling_on && $urandom_range(99) < 15))
                begin
                    item_valid <= 1'b1;
                    dout_lines <= pending_dout.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks every result transfer and stalls at random, once for a
    // long stretch so that the block backs up onto its input.
    always @(posedge clk)
    begin
        lcshd_pkg::result_t got;
        lcshd_pkg::result_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                got.sck_lines = sck_lines;
                got.reading_valid = reading_valid;
                got.reading_channel = reading_channel;
                got.reading_value = reading_value;
                got.sweep_done = sweep_done;
                got.hit = hit;
                results_taken <= results_taken + 1;
                if (expected_results.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result %0d arrived with nothing expected: %p",
                                 results_taken, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.sck_lines !== want.sck_lines
                        || got.reading_valid !== want.reading_valid
                        || got.reading_channel !== want.reading_channel
                        || got.reading_value !== want.reading_value
                        || got.sweep_done !== want.sweep_done
                        || got.hit !== want.hit)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("result %0d: expected sck=%h rv=%b ch=%0d val=%h sw=%b hit=%b",
                                     results_taken, want.sck_lines, want.reading_valid,
                                     want.reading_channel, want.reading_value,
                                     want.sweep_done, want.hit);
                            $display("          got      sck=%h rv=%b ch=%0d val=%h sw=%b hit=%b",
                                     got.sck_lines, got.reading_valid, got.reading_channel,
                                     got.reading_value, got.sweep_done, got.hit);
                        end
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                result_ready <= 1'b0;
            end
            else if (!hold_done && results_taken >= HoldAfter)
            begin
                hold_done <= 1'b1;
                hold_left <= HoldCycles;
                result_ready <= 1'b0;
            end
            else
                result_ready <= !(idling_on && $urandom_range(99) < 15);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("load_cell_scan_hit_detector_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [lcshd_pkg::ChanCount-1:0] mask_plan [5];
        logic [lcshd_pkg::ChanCount-1:0] mask;
        logic [lcshd_pkg::ThreshW-1:0]   limit;
        mask_plan = '{4'h0, 4'hF, 4'h1, 4'h8, 4'h5};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OpeningTicks[i])
            pending_dout.push_back(OpeningTicks[i]);
        wait_drained();

        // Settings change between phases, often while a read is half done.
        for (int p = 0; p < 8; p++)
        begin
            mask = (p < 5) ? mask_plan[p] : lcshd_pkg::ChanCount'($urandom_range(15));
            write_reg(lcshd_pkg::REG_ENABLE_MASK, lcshd_pkg::DataW'(mask));
            for (int k = 0; k < lcshd_pkg::ChanCount; k++)
            begin
                if (p == 0)
                    limit = '0;
                else if (p == 1)
                    limit = '1;
                else
                    limit = draw_threshold();
                write_reg(lcshd_pkg::cfg_reg_t'(int'(lcshd_pkg::REG_THRESHOLD_0) + k),
                          lcshd_pkg::DataW'(limit));
            end
            idling_on = (p != 1);
            queue_ticks((p == 0) ? 120 : 230);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("load_cell_scan_hit_detector_tb OK");
        else
            $display("load_cell_scan_hit_detector_tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/lcshd_pkg.sv
src/load_cell_scan_hit_detector.sv
verif/load_cell_scan_hit_detector_tb.sv
